// File: hw/rtl/convex_hull_graham_scan_macros.svh
// assertion macros used by the checker file
`ifndef CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define CVH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet while reset is held
`define CVH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/cvh_pkg.sv
package cvh_pkg;

  // widths of the channel fields
  localparam int FIELD_W = 16;
  localparam int SIZE_W  = 7;

  // point memory write data select
  typedef enum logic [1:0] {
    WR_IN,
    WR_T,
    WR_U
  } cvh_wsel_e;

  // operand set for the geometry unit
  typedef enum logic {
    GEO_SORT,
    GEO_SCAN
  } cvh_geo_e;

  // commands from controller to datapath
  typedef struct packed {
    logic      pt_wr;
    cvh_wsel_e pt_wsel;
    logic      pt_rd;
    logic      piv_rd;
    logic      piv_first;
    logic      ld_t;
    logic      ld_u;
    logic      ld_c;
    logic      geo_go;
    cvh_geo_e  geo_mode;
    logic      stk_wr;
    logic      stk_rd;
    logic      out_ld;
    logic      out_last;
  } cvh_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic geo_done;
    logic ahead;
    logic left;
  } cvh_sts_t;

endpackage

// File: hw/rtl/cvh_ifs.sv
// point request channel
interface cvh_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [cvh_pkg::FIELD_W-1:0] point_x;
  logic signed [cvh_pkg::FIELD_W-1:0] point_y;
  logic                               is_last_point;

  modport source (output valid, output point_x, output point_y, output is_last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input is_last_point,
                  output ready);
endinterface

// hull vertex request channel
interface cvh_hull_if;
  logic                               valid;
  logic                               ready;
  logic signed [cvh_pkg::FIELD_W-1:0] hull_x;
  logic signed [cvh_pkg::FIELD_W-1:0] hull_y;
  logic        [cvh_pkg::SIZE_W-1:0]  hull_size;
  logic                               is_last_vertex;

  modport source (output valid, output hull_x, output hull_y, output hull_size,
                  output is_last_vertex, input ready);
  modport sink   (input valid, input hull_x, input hull_y, input hull_size,
                  input is_last_vertex, output ready);
endinterface

// File: hw/rtl/cvh_geom.sv
module cvh_geom #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic signed [COORD_BITS-1:0] ox_i,
  input  logic signed [COORD_BITS-1:0] oy_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output logic                         done_o,
  output logic                         left_o,
  output logic                         before_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic              v1_q, v2_q, v3_q;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q;
  logic signed [PW-1:0] p1_q, p2_q, q1_q, q2_q, q3_q, q4_q;
  logic signed [SW-1:0] cr_q, da_q, db_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= go_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // differences, products, then sums
  always_ff @(posedge clk_i) begin
    dax_q <= DW'(ax_i) - DW'(ox_i);
    day_q <= DW'(ay_i) - DW'(oy_i);
    dbx_q <= DW'(bx_i) - DW'(ox_i);
    dby_q <= DW'(by_i) - DW'(oy_i);
    p1_q  <= PW'(dax_q) * PW'(dby_q);
    p2_q  <= PW'(day_q) * PW'(dbx_q);
    q1_q  <= PW'(dax_q) * PW'(dax_q);
    q2_q  <= PW'(day_q) * PW'(day_q);
    q3_q  <= PW'(dbx_q) * PW'(dbx_q);
    q4_q  <= PW'(dby_q) * PW'(dby_q);
    cr_q  <= SW'(p1_q) - SW'(p2_q);
    da_q  <= SW'(q1_q) + SW'(q2_q);
    db_q  <= SW'(q3_q) + SW'(q4_q);
  end

  // turn sign, nearer point wins on a collinear tie
  assign done_o   = v3_q;
  assign left_o   = cr_q > 0;
  assign before_o = (cr_q != 0) ? (cr_q > 0) : (da_q < db_q);

endmodule

// File: hw/rtl/cvh_dpath.sv
module cvh_dpath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [cvh_pkg::FIELD_W-1:0] in_x_i,
  input  logic signed [cvh_pkg::FIELD_W-1:0] in_y_i,
  input  cvh_pkg::cvh_cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]                   pt_waddr_i,
  input  logic [IDX_W-1:0]                   pt_raddr_i,
  input  logic [IDX_W-1:0]                   stk_waddr_i,
  input  logic [IDX_W-1:0]                   stk_raddr0_i,
  input  logic [IDX_W-1:0]                   stk_raddr1_i,
  input  logic [CNT_W-1:0]                   out_size_i,
  output cvh_pkg::cvh_sts_t                  sts_o,
  output logic signed [cvh_pkg::FIELD_W-1:0] out_x_o,
  output logic signed [cvh_pkg::FIELD_W-1:0] out_y_o,
  output logic [cvh_pkg::SIZE_W-1:0]         out_size_o,
  output logic                               out_last_o
);

  localparam int CB = COORD_BITS;
  localparam int FW = cvh_pkg::FIELD_W;

  logic signed [CB-1:0] pt_x_mem [MAX_POINTS];
  logic signed [CB-1:0] pt_y_mem [MAX_POINTS];
  logic signed [CB-1:0] stk_x_mem [MAX_POINTS];
  logic signed [CB-1:0] stk_y_mem [MAX_POINTS];

  logic [FW+CB-1:0]     in_x_ext, in_y_ext, out_x_ext, out_y_ext;
  logic signed [CB-1:0] in_x, in_y, wr_x, wr_y;
  logic signed [CB-1:0] prx_q, pry_q, s0x_q, s0y_q, s1x_q, s1y_q;
  logic signed [CB-1:0] px_q, py_q, tx_q, ty_q, ux_q, uy_q, cx_q, cy_q;
  logic signed [CB-1:0] ox, oy, ax, ay, bx, by, hx_q, hy_q;
  logic                 pvv_q, pf_q, piv_less;
  logic [cvh_pkg::SIZE_W-1:0] size_q;
  logic                 last_q;
  logic                 geo_done, geo_left, geo_before;

  // low coordinate bits of the request fields
  assign in_x_ext = {{CB{1'b0}}, in_x_i};
  assign in_y_ext = {{CB{1'b0}}, in_y_i};
  assign in_x     = in_x_ext[CB-1:0];
  assign in_y     = in_y_ext[CB-1:0];

  // point memory write data
  always_comb begin
    case (cmd_i.pt_wsel)
      cvh_pkg::WR_IN: begin
        wr_x = in_x;
        wr_y = in_y;
      end
      cvh_pkg::WR_T: begin
        wr_x = tx_q;
        wr_y = ty_q;
      end
      default: begin
        wr_x = ux_q;
        wr_y = uy_q;
      end
    endcase
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_wr) begin
      pt_x_mem[pt_waddr_i] <= wr_x;
      pt_y_mem[pt_waddr_i] <= wr_y;
    end
    if (cmd_i.pt_rd) begin
      prx_q <= pt_x_mem[pt_raddr_i];
      pry_q <= pt_y_mem[pt_raddr_i];
    end
  end

  // hull stack memory, two read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_wr) begin
      stk_x_mem[stk_waddr_i] <= cx_q;
      stk_y_mem[stk_waddr_i] <= cy_q;
    end
    if (cmd_i.stk_rd) begin
      s0x_q <= stk_x_mem[stk_raddr0_i];
      s0y_q <= stk_y_mem[stk_raddr0_i];
      s1x_q <= stk_x_mem[stk_raddr1_i];
      s1y_q <= stk_y_mem[stk_raddr1_i];
    end
  end

  // pivot search follows the read in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvv_q <= 1'b0;
      pf_q  <= 1'b0;
    end else begin
      pvv_q <= cmd_i.piv_rd;
      pf_q  <= cmd_i.piv_first;
    end
  end

  assign piv_less = (prx_q < px_q) || ((prx_q == px_q) && (pry_q < py_q));

  // pivot and working points
  always_ff @(posedge clk_i) begin
    if (pvv_q && (pf_q || piv_less)) begin
      px_q <= prx_q;
      py_q <= pry_q;
    end
    if (cmd_i.ld_t) begin
      tx_q <= prx_q;
      ty_q <= pry_q;
    end
    if (cmd_i.ld_u) begin
      ux_q <= prx_q;
      uy_q <= pry_q;
    end
    if (cmd_i.ld_c) begin
      cx_q <= prx_q;
      cy_q <= pry_q;
    end
  end

  // geometry operands
  always_comb begin
    case (cmd_i.geo_mode)
      cvh_pkg::GEO_SORT: begin
        ox = px_q;
        oy = py_q;
        ax = tx_q;
        ay = ty_q;
        bx = prx_q;
        by = pry_q;
      end
      default: begin
        ox = s0x_q;
        oy = s0y_q;
        ax = cx_q;
        ay = cy_q;
        bx = s1x_q;
        by = s1y_q;
      end
    endcase
  end

  cvh_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (cmd_i.geo_go),
    .ox_i    (ox),
    .oy_i    (oy),
    .ax_i    (ax),
    .ay_i    (ay),
    .bx_i    (bx),
    .by_i    (by),
    .done_o  (geo_done),
    .left_o  (geo_left),
    .before_o(geo_before)
  );

  assign sts_o.geo_done = geo_done;
  assign sts_o.ahead    = geo_before;
  assign sts_o.left     = geo_left;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      hx_q   <= s0x_q;
      hy_q   <= s0y_q;
      size_q <= cvh_pkg::SIZE_W'(out_size_i);
      last_q <= cmd_i.out_last;
    end
  end

  assign out_x_ext  = {{FW{1'b0}}, hx_q};
  assign out_y_ext  = {{FW{1'b0}}, hy_q};
  assign out_x_o    = out_x_ext[FW-1:0];
  assign out_y_o    = out_y_ext[FW-1:0];
  assign out_size_o = size_q;
  assign out_last_o = last_q;

endmodule

// File: hw/rtl/cvh_ctrl.sv
module cvh_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  input  cvh_pkg::cvh_sts_t sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output cvh_pkg::cvh_cmd_t cmd_o,
  output logic [IDX_W-1:0]  pt_waddr_o,
  output logic [IDX_W-1:0]  pt_raddr_o,
  output logic [IDX_W-1:0]  stk_waddr_o,
  output logic [IDX_W-1:0]  stk_raddr0_o,
  output logic [IDX_W-1:0]  stk_raddr1_o,
  output logic [CNT_W-1:0]  out_size_o
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIV,
    ST_PIV_END,
    ST_S_RDT,
    ST_S_LDT,
    ST_S_J,
    ST_S_LDU,
    ST_S_WAIT,
    ST_C_RD,
    ST_C_LDC,
    ST_C_STK,
    ST_C_GO,
    ST_C_WAIT,
    ST_O_RD,
    ST_O_LD,
    ST_O_HS
  } state_e;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] One    = CNT_W'(1);
  localparam logic [CNT_W-1:0] Two    = CNT_W'(2);

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q, n_q, i_q, j_q, dep_q;
  logic             in_ready_q, out_valid_q;
  logic             in_acc, i_end, k_end;
  logic [CNT_W-1:0] j_m1, dep_m1, dep_m2;

  assign in_acc = in_valid_i && in_ready_q;
  assign i_end  = (i_q + One) == n_q;
  assign k_end  = (i_q + One) == dep_q;
  assign j_m1   = j_q - One;
  assign dep_m1 = dep_q - One;
  assign dep_m2 = dep_q - Two;

  // sequencer: load, pivot, insertion sort, stack scan, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      dep_q       <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (cnt_q < MaxCnt) cnt_q <= cnt_q + One;
            if (in_last_i) begin
              n_q        <= (cnt_q < MaxCnt) ? cnt_q + One : cnt_q;
              i_q        <= '0;
              in_ready_q <= 1'b0;
              state_q    <= ST_PIV;
            end
          end
        end
        ST_PIV: begin
          i_q <= i_q + One;
          if (i_end) state_q <= ST_PIV_END;
        end
        ST_PIV_END: begin
          if (n_q < Two) begin
            i_q     <= '0;
            dep_q   <= '0;
            state_q <= ST_C_RD;
          end else begin
            i_q     <= One;
            state_q <= ST_S_RDT;
          end
        end
        ST_S_RDT: state_q <= ST_S_LDT;
        ST_S_LDT: begin
          j_q     <= i_q;
          state_q <= ST_S_J;
        end
        ST_S_J: begin
          if (j_q == '0) begin
            if (i_end) begin
              i_q     <= '0;
              dep_q   <= '0;
              state_q <= ST_C_RD;
            end else begin
              i_q     <= i_q + One;
              state_q <= ST_S_RDT;
            end
          end else begin
            state_q <= ST_S_LDU;
          end
        end
        ST_S_LDU: state_q <= ST_S_WAIT;
        ST_S_WAIT: begin
          if (sts_i.geo_done) begin
            if (sts_i.ahead) begin
              j_q     <= j_m1;
              state_q <= ST_S_J;
            end else if (i_end) begin
              i_q     <= '0;
              dep_q   <= '0;
              state_q <= ST_C_RD;
            end else begin
              i_q     <= i_q + One;
              state_q <= ST_S_RDT;
            end
          end
        end
        ST_C_RD:  state_q <= ST_C_LDC;
        ST_C_LDC: state_q <= ST_C_STK;
        ST_C_STK: begin
          if (dep_q < Two) begin
            dep_q <= dep_q + One;
            if (i_end) begin
              i_q     <= '0;
              state_q <= ST_O_RD;
            end else begin
              i_q     <= i_q + One;
              state_q <= ST_C_RD;
            end
          end else begin
            state_q <= ST_C_GO;
          end
        end
        ST_C_GO: state_q <= ST_C_WAIT;
        ST_C_WAIT: begin
          if (sts_i.geo_done) begin
            if (!sts_i.left) begin
              dep_q   <= dep_m1;
              state_q <= ST_C_STK;
            end else begin
              dep_q <= dep_q + One;
              if (i_end) begin
                i_q     <= '0;
                state_q <= ST_O_RD;
              end else begin
                i_q     <= i_q + One;
                state_q <= ST_C_RD;
              end
            end
          end
        end
        ST_O_RD: state_q <= ST_O_LD;
        ST_O_LD: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_O_HS;
        end
        ST_O_HS: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (k_end) begin
              cnt_q      <= '0;
              in_ready_q <= 1'b1;
              state_q    <= ST_LOAD;
            end else begin
              i_q     <= i_q + One;
              state_q <= ST_O_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.pt_wsel  = cvh_pkg::WR_IN;
    cmd_o.geo_mode = cvh_pkg::GEO_SORT;
    pt_waddr_o     = '0;
    pt_raddr_o     = '0;
    stk_waddr_o    = '0;
    stk_raddr0_o   = '0;
    stk_raddr1_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.pt_wr = in_acc && (cnt_q < MaxCnt);
        pt_waddr_o  = cnt_q[IDX_W-1:0];
      end
      ST_PIV: begin
        cmd_o.pt_rd     = 1'b1;
        cmd_o.piv_rd    = 1'b1;
        cmd_o.piv_first = (i_q == '0);
        pt_raddr_o      = i_q[IDX_W-1:0];
      end
      ST_S_RDT, ST_C_RD: begin
        cmd_o.pt_rd = 1'b1;
        pt_raddr_o  = i_q[IDX_W-1:0];
      end
      ST_S_LDT: cmd_o.ld_t = 1'b1;
      ST_S_J: begin
        if (j_q == '0) begin
          cmd_o.pt_wr   = 1'b1;
          cmd_o.pt_wsel = cvh_pkg::WR_T;
        end else begin
          cmd_o.pt_rd = 1'b1;
          pt_raddr_o  = j_m1[IDX_W-1:0];
        end
      end
      ST_S_LDU: begin
        cmd_o.ld_u   = 1'b1;
        cmd_o.geo_go = 1'b1;
      end
      ST_S_WAIT: begin
        cmd_o.pt_wr   = sts_i.geo_done;
        cmd_o.pt_wsel = sts_i.ahead ? cvh_pkg::WR_U : cvh_pkg::WR_T;
        pt_waddr_o    = j_q[IDX_W-1:0];
      end
      ST_C_LDC: cmd_o.ld_c = 1'b1;
      ST_C_STK: begin
        if (dep_q < Two) begin
          cmd_o.stk_wr = 1'b1;
          stk_waddr_o  = dep_q[IDX_W-1:0];
        end else begin
          cmd_o.stk_rd = 1'b1;
          stk_raddr0_o = dep_m1[IDX_W-1:0];
          stk_raddr1_o = dep_m2[IDX_W-1:0];
        end
      end
      ST_C_GO: begin
        cmd_o.geo_go   = 1'b1;
        cmd_o.geo_mode = cvh_pkg::GEO_SCAN;
      end
      ST_C_WAIT: begin
        cmd_o.geo_mode = cvh_pkg::GEO_SCAN;
        cmd_o.stk_wr   = sts_i.geo_done && sts_i.left;
        stk_waddr_o    = dep_q[IDX_W-1:0];
      end
      ST_O_RD: begin
        cmd_o.stk_rd = 1'b1;
        stk_raddr0_o = i_q[IDX_W-1:0];
      end
      ST_O_LD: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_last = k_end;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign out_size_o  = dep_q;

endmodule

// File: hw/rtl/convex_hull_graham_scan.sv
// points load at one request per cycle; after the last point a set of n points
// goes through a pivot pass, an insertion sort (up to n*(n-1)/2 compares) and a
// stack scan of cross-product tests, all on one geometry unit with a three-stage
// pipeline; each hull vertex is then read from the stack, loaded into the output
// register and held until it is taken.
// reset is asynchronous, active low: empty point set, idle and ready.
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  cvh_point_if.sink  pt_i,
  cvh_hull_if.source hull_o
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  cvh_pkg::cvh_cmd_t cmd;
  cvh_pkg::cvh_sts_t sts;
  logic [IDX_W-1:0]  pt_waddr, pt_raddr, stk_waddr, stk_raddr0, stk_raddr1;
  logic [CNT_W-1:0]  out_size;

  // sequencer
  cvh_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pt_i.valid),
    .in_last_i   (pt_i.is_last_point),
    .out_ready_i (hull_o.ready),
    .sts_i       (sts),
    .in_ready_o  (pt_i.ready),
    .out_valid_o (hull_o.valid),
    .cmd_o       (cmd),
    .pt_waddr_o  (pt_waddr),
    .pt_raddr_o  (pt_raddr),
    .stk_waddr_o (stk_waddr),
    .stk_raddr0_o(stk_raddr0),
    .stk_raddr1_o(stk_raddr1),
    .out_size_o  (out_size)
  );

  // memories, geometry and output register
  cvh_dpath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_x_i      (pt_i.point_x),
    .in_y_i      (pt_i.point_y),
    .cmd_i       (cmd),
    .pt_waddr_i  (pt_waddr),
    .pt_raddr_i  (pt_raddr),
    .stk_waddr_i (stk_waddr),
    .stk_raddr0_i(stk_raddr0),
    .stk_raddr1_i(stk_raddr1),
    .out_size_i  (out_size),
    .sts_o       (sts),
    .out_x_o     (hull_o.hull_x),
    .out_y_o     (hull_o.hull_y),
    .out_size_o  (hull_o.hull_size),
    .out_last_o  (hull_o.is_last_vertex)
  );

endmodule

// File: hw/rtl/cvh_checker.sv
`include "convex_hull_graham_scan_macros.svh"

module cvh_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [cvh_pkg::FIELD_W-1:0] hull_x_i,
  input logic signed [cvh_pkg::FIELD_W-1:0] hull_y_i,
  input logic        [cvh_pkg::SIZE_W-1:0]  hull_size_i,
  input logic                               out_last_i
);

  // no point is taken while a vertex is on offer
  `CVH_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i)

  // a one-vertex hull is marked last
  `CVH_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_i && (hull_size_i == 1), out_last_i)

  // the last vertex taken frees the point channel
  `CVH_ASSERT_NXT(a_reload, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_i, in_ready_i)

  // a stalled vertex holds
  `CVH_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(hull_x_i) && $stable(hull_y_i))

endmodule

bind convex_hull_graham_scan cvh_checker u_cvh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (pt_i.ready),
  .out_valid_i(hull_o.valid),
  .out_ready_i(hull_o.ready),
  .hull_x_i   (hull_o.hull_x),
  .hull_y_i   (hull_o.hull_y),
  .hull_size_i(hull_o.hull_size),
  .out_last_i (hull_o.is_last_vertex)
);
